>>> hdl/indexed_list_insert_remove_unit_assert.svh
// Assertion macros for the indexed list insert/remove unit.
`ifndef INDEXED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ILR_ASSERT_NOW(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ilr check failed");
`define ILR_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ilr check failed");
`else
`define ILR_ASSERT_NOW(name, cond)
`define ILR_ASSERT_NEXT(name, pre, post)
`endif
`endif

>>> hdl/ilr_pkg.sv
// Shared constants, codes and types of the indexed list insert/remove unit.
package ilr_pkg;
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int KIND_W   = 3;
	localparam int POS_W    = 7;
	localparam int STAT_W   = 2;
	localparam int SIZE_W   = 7;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [KIND_W-1:0] K_PUSH_BACK  = KIND_W'(0);
	localparam logic [KIND_W-1:0] K_PUSH_FRONT = KIND_W'(1);
	localparam logic [KIND_W-1:0] K_INSERT     = KIND_W'(2);
	localparam logic [KIND_W-1:0] K_POP_BACK   = KIND_W'(3);
	localparam logic [KIND_W-1:0] K_POP_FRONT  = KIND_W'(4);
	localparam logic [KIND_W-1:0] K_REMOVE     = KIND_W'(5);
	localparam logic [KIND_W-1:0] K_CLEAR      = KIND_W'(6);

	localparam logic [STAT_W-1:0] ST_OK    = STAT_W'(0);
	localparam logic [STAT_W-1:0] ST_RANGE = STAT_W'(1);
	localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(2);

	localparam logic [DATA_W-1:0] NONE_VALUE = -DATA_W'(404);

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [CMP_W-1:0]  at;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;
endpackage

>>> hdl/indexed_list_insert_remove_unit.sv
// Top level of the indexed list insert/remove unit: decode, cell row, result registers.
// Usage:
//   A request (kind, value, position) is taken at a rising edge with start high
//   and busy low. busy stays low: a new request may follow in every cycle.
//   Each request gives one result (removed_value, status, size) in the cycle
//   after it is taken, shown for exactly one cycle with done high. The receiver cannot
//   stall, so results must be taken when done is high.
//   Throughput is one request per cycle: every cell at or above the position
//   loads from its left or right neighbor, or takes the new value, in the same
//   cycle, so an insert or removal anywhere in the list completes in a single shift.
//   The removed entry is picked by a one-hot OR of the cell taps.
//   Reset clears the entry count and the done strobe; cell contents stay
//   undefined until written, and only cells below the count are ever read.
//   After a clear, size reads zero and removed_value reads -404.
`include "indexed_list_insert_remove_unit_assert.svh"
module indexed_list_insert_remove_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ilr_pkg::KIND_W-1:0] kind,
	input  logic [ilr_pkg::DATA_W-1:0] value,
	input  logic [ilr_pkg::POS_W-1:0]  position,
	output logic                       done,
	output logic [ilr_pkg::DATA_W-1:0] removed_value,
	output logic [ilr_pkg::STAT_W-1:0] status,
	output logic [ilr_pkg::SIZE_W-1:0] size
);
	import ilr_pkg::*;

	cell_ctl_t         ctl;
	logic [STAT_W-1:0] status_next;
	logic [CNT_W-1:0]  count;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_tap  [CAPACITY];
	logic [DATA_W-1:0] tap_or;
	logic [DATA_W-1:0] removed_next;
	logic              done_q;
	logic [DATA_W-1:0] removed_value_q;
	logic [STAT_W-1:0] status_q;

	ilr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.value       (value),
		.position    (position),
		.ctl         (ctl),
		.status_next (status_next),
		.count       (count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		ilr_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.idx        (CMP_W'(i)),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	always_comb begin
		tap_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			tap_or = tap_or | cell_tap[k];
		end
	end

	assign removed_next = ctl.rem ? tap_or : NONE_VALUE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			removed_value_q <= removed_next;
			status_q        <= status_next;
		end
	end

	assign busy          = 1'b0;
	assign done          = done_q;
	assign removed_value = removed_value_q;
	assign status        = status_q;
	assign size          = SIZE_W'(count);

	`ILR_ASSERT_NOW(a_count_bound, count <= CNT_W'(CAPACITY))
	`ILR_ASSERT_NEXT(a_one_result, start, done)
	`ILR_ASSERT_NEXT(a_no_spurious, !start, !done)
	`ILR_ASSERT_NEXT(a_err_keeps_size, start && (status_next != ST_OK), size == $past(size))
	`ILR_ASSERT_NOW(a_err_none_value, !(done && (status != ST_OK)) || (removed_value == NONE_VALUE))
endmodule

>>> hdl/ilr_cell.sv
// One list cell: holds an entry and shifts toward or away from its neighbors.
module ilr_cell (
	input  logic                       clk,
	input  ilr_pkg::cell_ctl_t         ctl,
	input  logic [ilr_pkg::CMP_W-1:0]  idx,
	input  logic [ilr_pkg::DATA_W-1:0] left_data,
	input  logic [ilr_pkg::DATA_W-1:0] right_data,
	output logic [ilr_pkg::DATA_W-1:0] data,
	output logic [ilr_pkg::DATA_W-1:0] tap
);
	import ilr_pkg::*;

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx > ctl.at) begin
				data_q <= left_data;
			end else if (idx == ctl.at) begin
				data_q <= ctl.value;
			end
		end else if (ctl.rem && (idx >= ctl.at)) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
	assign tap  = (idx == ctl.at) ? data_q : '0;
endmodule

>>> hdl/ilr_ctrl.sv
// Request decode and entry count of the indexed list insert/remove unit.
module ilr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ilr_pkg::KIND_W-1:0] kind,
	input  logic [ilr_pkg::DATA_W-1:0] value,
	input  logic [ilr_pkg::POS_W-1:0]  position,
	output ilr_pkg::cell_ctl_t         ctl,
	output logic [ilr_pkg::STAT_W-1:0] status_next,
	output logic [ilr_pkg::CNT_W-1:0]  count
);
	import ilr_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic             full;
	logic             empty;
	logic             clear;

	assign pos_c = CMP_W'(position);
	assign cnt_c = CMP_W'(count_q);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		ctl.ins     = 1'b0;
		ctl.rem     = 1'b0;
		ctl.at      = '0;
		ctl.value   = value;
		status_next = ST_OK;
		clear       = 1'b0;
		case (kind)
			K_PUSH_BACK: begin
				ctl.at = cnt_c;
				if (full) status_next = ST_FULL;
				else ctl.ins = 1'b1;
			end
			K_PUSH_FRONT: begin
				if (full) status_next = ST_FULL;
				else ctl.ins = 1'b1;
			end
			K_INSERT: begin
				ctl.at = pos_c;
				if (pos_c > cnt_c) status_next = ST_RANGE;
				else if (full) status_next = ST_FULL;
				else ctl.ins = 1'b1;
			end
			K_POP_BACK: begin
				ctl.at = cnt_c - CMP_W'(1);
				if (empty) status_next = ST_RANGE;
				else ctl.rem = 1'b1;
			end
			K_POP_FRONT: begin
				if (empty) status_next = ST_RANGE;
				else ctl.rem = 1'b1;
			end
			K_REMOVE: begin
				ctl.at = pos_c;
				if (pos_c >= cnt_c) status_next = ST_RANGE;
				else ctl.rem = 1'b1;
			end
			K_CLEAR: begin
				clear = 1'b1;
			end
			default: begin
			end
		endcase
		if (!start) begin
			ctl.ins = 1'b0;
			ctl.rem = 1'b0;
			clear   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign count = count_q;
endmodule
